[hw/rtl/dtwlb_pkg.sv]
// Shared constants and types for the DTW lower-bound block.
// No dependencies.
package dtwlb_pkg;
  localparam int unsigned MaxRadius  = 64;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned QueueCap   = 2 * MaxRadius + 1;
  localparam int unsigned SumBits    = 47;
  localparam int unsigned PosBits    = 32;
  localparam int unsigned RadBits    = 7;
  localparam int unsigned DlyBits    = $clog2(MaxRadius);
  localparam int unsigned DiffBits   = SampleBits + 1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [SumBits-1:0] sum_t;
  typedef logic [PosBits-1:0] pos_t;

  // Queue cell entry: sample value and the position it came from.
  typedef struct packed {
    logic    vld;
    sample_t val;
    pos_t    idx;
  } qent_t;

  // Command broadcast along a queue chain.
  typedef struct packed {
    logic    push;
    logic    exp_en;
    pos_t    now;
    pos_t    span;
    sample_t val;
    pos_t    idx;
  } qcmd_t;

  function automatic sum_t sat_add(input sum_t a, input logic [DiffBits-1:0] b,
                                   output logic ovf);
    logic [SumBits:0] s;
    s = {1'b0, a} + {{(SumBits+1-DiffBits){1'b0}}, b};
    ovf = s[SumBits];
    sat_add = s[SumBits] ? {SumBits{1'b1}} : s[SumBits-1:0];
  endfunction
endpackage

[hw/rtl/dtwlb_qcell.sv]
// One cell of a monotonic queue held as a shift chain, head at cell 0.
// Depends on dtwlb_pkg.
module dtwlb_qcell import dtwlb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clr_i,
  input  logic  is_max_i,
  input  qcmd_t cmd_i,
  input  logic  head_exp_i,   // expiring count reaches this cell
  input  logic  prev_keep_i,  // previous cell survives expiry and push
  input  qent_t next_i,       // neighbor toward the tail
  input  logic  next_keep_i,
  input  logic  shift_i,      // shift toward head by one
  output logic  keep_o,
  output logic  expd_o,
  output qent_t ent_o
);
  qent_t ent_q, ent_d, src;
  logic dom;

  always_comb begin
    // A cell whose value the new sample dominates is dropped.
    dom = is_max_i ? (ent_q.val <= cmd_i.val) : (ent_q.val >= cmd_i.val);
    expd_o = ent_q.vld && cmd_i.exp_en && ((cmd_i.now - ent_q.idx) > cmd_i.span)
             && head_exp_i;
    keep_o = ent_q.vld && !expd_o && !(cmd_i.push && dom);
    src = shift_i ? next_i : ent_q;
    ent_d = src;
    if (shift_i) begin
      if (!next_keep_i) ent_d.vld = 1'b0;
    end else if (!keep_o) begin
      ent_d.vld = 1'b0;
    end
    // The tail slot takes the new sample.
    if (cmd_i.push && prev_keep_i && !ent_d.vld) begin
      ent_d.vld = 1'b1;
      ent_d.val = cmd_i.val;
      ent_d.idx = cmd_i.idx;
    end
    if (clr_i) ent_d.vld = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end
  assign ent_o = ent_q;
endmodule

[hw/rtl/dtwlb_queue.sv]
// Monotonic queue as a chain of cells; the front is always cell 0.
// Depends on dtwlb_pkg and dtwlb_qcell.
module dtwlb_queue import dtwlb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    clr_i,
  input  logic    is_max_i,
  input  qcmd_t   cmd_i,
  output logic    nonempty_o,
  output sample_t front_o,
  output logic    front_expd_o
);
  qent_t ent [QueueCap];
  logic  keep [QueueCap];
  logic  expd [QueueCap];
  logic  shf [QueueCap];

  // Expired entries form a prefix, so only the front can expire in one step;
  // dominated ones form a suffix. Removal of the front shifts the chain.
  genvar g;
  generate
    for (g = 0; g < int'(QueueCap); g++) begin : g_cell
      qent_t nx;
      logic  nk;
      logic  pk;
      if (g == int'(QueueCap) - 1) begin : g_end
        assign nx = '0;
        assign nk = 1'b0;
      end else begin : g_mid
        assign nx = ent[g+1];
        assign nk = keep[g+1];
      end
      if (g == 0) begin : g_h
        assign pk = 1'b1;
      end else begin : g_t
        assign pk = keep[g-1];
      end
      assign shf[g] = expd[0];
      dtwlb_qcell u_cell (
        .clk_i, .rst_ni, .clr_i, .is_max_i, .cmd_i,
        .head_exp_i (g == 0),
        .prev_keep_i(pk),
        .next_i     (nx),
        .next_keep_i(nk),
        .shift_i    (shf[g]),
        .keep_o     (keep[g]),
        .expd_o     (expd[g]),
        .ent_o      (ent[g])
      );
    end
  endgenerate

  assign nonempty_o   = ent[0].vld;
  assign front_o      = ent[0].val;
  assign front_expd_o = expd[0];
endmodule

[hw/rtl/dtw_lower_bound_improved_top.sv]
// Top level of the DTW lower-bound block (envelope bound and its two-pass refinement).
// Depends on dtwlb_pkg and dtwlb_queue.
//
// Each item carries one series index. Items are taken one at a time; an
// ordinary item passes through expire, push, score, write-back and idle
// before the next one is accepted, with an extra expiry step for each stale
// queue front that has to be dropped first. The item marked last then runs
// one step per tail index, at most r steps, each again stretched by any front
// expiry, before its result is shown; the next item is accepted only after
// that result is taken. Queue fronts expire one entry per step, so the
// sequencer repeats an expiry step while the front is stale.
module dtw_lower_bound_improved_top import dtwlb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RadBits-1:0]    cfg_data_i,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               candidate_sample_i,
  input  sample_t               query_sample_i,
  input  sample_t               upper_sample_i,
  input  sample_t               lower_sample_i,
  input  logic                  last_item_i,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SumBits-1:0]    keogh_bound_o,
  output logic [SumBits-1:0]    improved_bound_o,
  output logic                  saturated_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_EXP, ST_PUSH, ST_TAIL_EXP, ST_TAIL_SCORE, ST_OUT
  } state_e;

  state_e  state_q;
  logic [RadBits-1:0] rad_q;
  logic [RadBits-1:0] r;
  sample_t cand_q, qry_q, up_q, lo_q, clip_q;
  logic    last_q;
  pos_t    pos_q, seen_q;
  sum_t    s1_q, s2_q;
  logic    ovf_q;
  logic [DlyBits-1:0] wr_q;
  logic [RadBits-1:0] k_q;
  sample_t dly [MaxRadius];
  sample_t dly_rd_q;
  logic    out_valid_q;
  sum_t    kb_q, ib_q;
  logic    sat_q;

  qcmd_t   cmd;
  logic    clr;
  logic    mx_ne, mn_ne, mx_ex, mn_ex;
  sample_t mx_f, mn_f;

  assign r = (rad_q > RadBits'(MaxRadius)) ? RadBits'(MaxRadius) : rad_q;
  assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_stall  = !((state_q == ST_IDLE) && !out_valid_q);

  logic [PosBits-1:0] kmax;
  assign kmax = (PosBits'(r) - 1 > seen_q) ? seen_q : PosBits'(r) - 1;

  // Clip result of pass one.
  sample_t clip_c;
  logic [DiffBits-1:0] d1;
  always_comb begin
    clip_c = cand_q;
    d1 = '0;
    if (cand_q > up_q) begin
      clip_c = up_q;
      d1 = DiffBits'({cand_q[SampleBits-1], cand_q} - {up_q[SampleBits-1], up_q});
    end else if (cand_q < lo_q) begin
      clip_c = lo_q;
      d1 = DiffBits'({lo_q[SampleBits-1], lo_q} - {cand_q[SampleBits-1], cand_q});
    end
  end

  // The delay read is registered, so the address looks one step ahead: the
  // tap that the next cycle scores is fetched in this one.
  logic [RadBits-1:0] back;
  always_comb begin
    back = k_q;
    if (state_q == ST_PUSH) begin
      back = r;
    end else if (state_q == ST_TAIL_SCORE) begin
      back = RadBits'(kmax);
    end else if (state_q == ST_TAIL_EXP && !(mx_ex || mn_ex) && k_q != '0) begin
      back = k_q - 1'b1;
    end
  end
  logic [DlyBits-1:0] rd_addr;
  assign rd_addr = wr_q - DlyBits'(back);

  always_ff @(posedge clk_i) begin
    dly_rd_q <= dly[rd_addr];
    if (state_q == ST_OUT && !out_valid_q) dly[wr_q] <= qry_q;
  end

  always_comb begin
    cmd = '0;
    cmd.now = pos_q;
    cmd.val = clip_q;
    cmd.idx = pos_q;
    cmd.span = {{(PosBits-RadBits-1){1'b0}}, r, 1'b0};
    if (state_q == ST_EXP) cmd.exp_en = 1'b1;
    if (state_q == ST_PUSH) cmd.push = 1'b1;
    if (state_q == ST_TAIL_EXP) begin
      cmd.exp_en = 1'b1;
      cmd.span = PosBits'(r) + PosBits'(k_q);
    end
  end
  assign clr = (state_q == ST_OUT) && out_valid_q && !out_stall;

  dtwlb_queue u_max (.clk_i, .rst_ni, .clr_i(clr), .is_max_i(1'b1), .cmd_i(cmd),
                     .nonempty_o(mx_ne), .front_o(mx_f), .front_expd_o(mx_ex));
  dtwlb_queue u_min (.clk_i, .rst_ni, .clr_i(clr), .is_max_i(1'b0), .cmd_i(cmd),
                     .nonempty_o(mn_ne), .front_o(mn_f), .front_expd_o(mn_ex));

  // Pass-two term; query value is current item when back is zero.
  sample_t qv;
  logic [DiffBits-1:0] d2;
  logic    t2;
  always_comb begin
    qv = (k_q == '0) ? qry_q : dly_rd_q;
    d2 = '0;
    t2 = mx_ne && mn_ne;
    if (qv > mx_f) d2 = DiffBits'({qv[SampleBits-1], qv} - {mx_f[SampleBits-1], mx_f});
    else if (qv < mn_f) d2 = DiffBits'({mn_f[SampleBits-1], mn_f} - {qv[SampleBits-1], qv});
  end

  logic o1, o2;
  sum_t s1n, s2n;
  always_comb begin
    s1n  = sat_add(s1_q, d1, o1);
    s2n  = sat_add(s2_q, d2, o2);
  end
  logic [SumBits:0] fin;
  assign fin = {1'b0, s1_q} + {1'b0, s2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; rad_q <= '0; pos_q <= '0; seen_q <= '0;
      s1_q <= '0; s2_q <= '0; ovf_q <= 1'b0; wr_q <= '0; k_q <= '0;
      out_valid_q <= 1'b0; last_q <= 1'b0;
      cand_q <= '0; qry_q <= '0; up_q <= '0; lo_q <= '0; clip_q <= '0;
      kb_q <= '0; ib_q <= '0; sat_q <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) rad_q <= cfg_data_i;
      if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cand_q <= candidate_sample_i; qry_q <= query_sample_i;
            up_q <= upper_sample_i; lo_q <= lower_sample_i;
            last_q <= last_item_i; k_q <= '0;
            state_q <= ST_EXP;
          end
        end
        ST_EXP: begin
          // Pass one is added once, on the step that leaves the expiry loop.
          if (!(mx_ex || mn_ex)) begin
            s1_q <= s1n; ovf_q <= ovf_q | o1; clip_q <= clip_c;
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          k_q <= (r == '0) ? '0 : 7'd1;
          state_q <= ST_TAIL_SCORE;
        end
        ST_TAIL_SCORE: begin
          if ((seen_q >= PosBits'(r)) && t2) begin
            s2_q <= s2n; ovf_q <= ovf_q | o2;
          end
          if (last_q && r != '0) begin
            k_q <= RadBits'(kmax);
            state_q <= ST_TAIL_EXP;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_TAIL_EXP: begin
          if (!(mx_ex || mn_ex)) begin
            if (t2) begin s2_q <= s2n; ovf_q <= ovf_q | o2; end
            if (k_q == '0) state_q <= ST_OUT;
            else k_q <= k_q - 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_valid_q) begin
            wr_q <= DlyBits'(wr_q + 1'b1);
            if (last_q) begin
              out_valid_q <= 1'b1;
              kb_q <= s1_q;
              ib_q <= fin[SumBits] ? '1 : fin[SumBits-1:0];
              sat_q <= ovf_q | fin[SumBits];
              pos_q <= '0; seen_q <= '0; s1_q <= '0; s2_q <= '0; ovf_q <= 1'b0;
            end else begin
              pos_q <= pos_q + 1'b1;
              if (seen_q != '1) seen_q <= seen_q + 1'b1;
              state_q <= ST_IDLE;
            end
          end else if (!out_stall) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_q;
  assign keogh_bound_o    = kb_q;
  assign improved_bound_o = ib_q;
  assign saturated_o      = sat_q;
endmodule
